// ===== hdl/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Shared constants, codes and types of the Sobol point generator.
// ----------------------------------------------------------------------------
package spg_pkg;

  // Sizing
  localparam int MAX_DIMS    = 32;
  localparam int MAX_COLUMNS = 31;

  // Fixed field widths
  localparam int WordW     = 31;
  localparam int FuncW     = 2;
  localparam int DimFieldW = 5;
  localparam int ColFieldW = 5;
  localparam int DimsCfgW  = 6;
  localparam int ColsCfgW  = 5;
  localparam int CntW      = 32;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 6;
  localparam int CmpW      = 8;

  // Derived internal widths
  localparam int DimW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ColW   = $clog2(MAX_COLUMNS + 1);
  localparam int AddrW  = DimW + ColW;
  localparam int TblDepth = 2 ** AddrW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDimensions  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 2'd1;

  // Request function codes
  typedef enum logic [FuncW-1:0] {
    FuncLoad    = 2'd0,
    FuncNext    = 2'd1,
    FuncRestart = 2'd2
  } func_e;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StScan    = 4'b0010,
    StEmit    = 4'b0100,
    StExhaust = 4'b1000
  } state_e;

  // Control from the sequencer to the coordinate store
  typedef struct packed {
    logic            clear;
    logic            update;
    logic            xor_en;
    logic [DimW-1:0] dim;
  } coord_ctrl_t;

  // Fraction mask of a given number of column bits
  function automatic logic [WordW-1:0] frac_mask(input logic [ColsCfgW-1:0] cols);
    logic [CntW-1:0] m;
    m = (CntW'(32'h1) << cols) - CntW'(32'h1);
    return m[WordW-1:0];
  endfunction

endpackage

// ===== hdl/spg_if.sv =====
// ----------------------------------------------------------------------------
// spg_if
// Request and result channels of the Sobol point generator.
// ----------------------------------------------------------------------------
interface spg_req_if;
  logic                               valid;
  logic                               ready;
  logic [spg_pkg::FuncW-1:0]          func;
  logic [spg_pkg::DimFieldW-1:0]      dim_index;
  logic [spg_pkg::ColFieldW-1:0]      column_index;
  logic [spg_pkg::WordW-1:0]          direction_value;

  modport source (output valid, func, dim_index, column_index, direction_value,
                  input ready);
  modport sink   (input valid, func, dim_index, column_index, direction_value,
                  output ready);
endinterface

interface spg_res_if;
  logic                          valid;
  logic                          ready;
  logic [spg_pkg::WordW-1:0]     coordinate;
  logic [spg_pkg::DimFieldW-1:0] coord_dim;
  logic                          status;
  logic                          last;

  modport source (output valid, coordinate, coord_dim, status, last, input ready);
  modport sink   (input valid, coordinate, coord_dim, status, last, output ready);
endinterface

// ===== hdl/sobol_point_generator.sv =====
// ----------------------------------------------------------------------------
// sobol_point_generator
// Gray-code Sobol point generator with a loadable direction number table.
// ----------------------------------------------------------------------------
// Load and restart requests give no result. A next request, once accepted,
// searches the point counter for its lowest zero bit (one counter bit
// tested per cycle, bounded by column_count) and then emits the dimensions
// in turn while the output register is free: one direction table read and
// one XOR through the shared update unit each cycle. The first point after
// a restart skips the search; a search that reaches column_count gives a
// single exhausted result. The request channel is not ready until the last
// result of a next request has entered the output register. The direction
// table has no reset and no clearing pass; reading a word never loaded
// gives anything.
// ----------------------------------------------------------------------------
module sobol_point_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  spg_req_if.sink                       req_i,
  spg_res_if.source                     res_o
);

  spg_pkg::state_e             state_q, state_d;
  logic [spg_pkg::DimsCfgW-1:0] dims_q;
  logic [spg_pkg::ColsCfgW-1:0] cols_q;
  logic [spg_pkg::CntW-1:0]    counter_q, counter_d;
  logic                        started_q, started_d;
  logic [spg_pkg::ColW-1:0]    col_q, col_d;
  logic [spg_pkg::DimW-1:0]    dim_q, dim_d;
  logic                        xor_en_q, xor_en_d;

  logic                        out_valid_q;
  logic [spg_pkg::WordW-1:0]   out_coord_q;
  logic [spg_pkg::DimFieldW-1:0] out_dim_q;
  logic                        out_status_q;
  logic                        out_last_q;

  logic [spg_pkg::DimsCfgW-1:0] eff_dims;
  logic [spg_pkg::ColsCfgW-1:0] eff_cols;
  logic [spg_pkg::DimW-1:0]    last_dim;
  logic [spg_pkg::WordW-1:0]   mask;

  logic                        req_fire;
  logic                        out_free;
  logic                        out_load;
  logic [spg_pkg::WordW-1:0]   out_coord_d;
  logic [spg_pkg::DimFieldW-1:0] out_dim_d;
  logic                        out_status_d;
  logic                        out_last_d;

  logic                        tbl_we;
  logic [spg_pkg::AddrW-1:0]   tbl_waddr;
  logic                        tbl_re;
  logic [spg_pkg::AddrW-1:0]   tbl_raddr;
  logic [spg_pkg::WordW-1:0]   dir_word;

  spg_pkg::coord_ctrl_t        cctl;
  logic [spg_pkg::WordW-1:0]   new_coord;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= spg_pkg::DimsCfgW'(1);
      cols_q <= spg_pkg::ColsCfgW'(31);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spg_pkg::CfgDimensions:  dims_q <= cfg_wdata_i;
        spg_pkg::CfgColumnCount: cols_q <= cfg_wdata_i[spg_pkg::ColsCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Effective configuration
  always_comb begin
    if (dims_q == '0) begin
      eff_dims = spg_pkg::DimsCfgW'(1);
    end else if (spg_pkg::CmpW'(dims_q) > spg_pkg::CmpW'(spg_pkg::MAX_DIMS)) begin
      eff_dims = spg_pkg::DimsCfgW'(spg_pkg::MAX_DIMS);
    end else begin
      eff_dims = dims_q;
    end
    if (spg_pkg::CmpW'(cols_q) > spg_pkg::CmpW'(spg_pkg::MAX_COLUMNS)) begin
      eff_cols = spg_pkg::ColsCfgW'(spg_pkg::MAX_COLUMNS);
    end else begin
      eff_cols = cols_q;
    end
  end

  assign last_dim = spg_pkg::DimW'(eff_dims - spg_pkg::DimsCfgW'(1));
  assign mask     = spg_pkg::frac_mask(eff_cols);

  // Handshake
  assign req_i.ready = (state_q == spg_pkg::StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign tbl_waddr   = {spg_pkg::DimW'(req_i.dim_index), spg_pkg::ColW'(req_i.column_index)};

  // Sequencer
  always_comb begin
    state_d      = state_q;
    counter_d    = counter_q;
    started_d    = started_q;
    col_d        = col_q;
    dim_d        = dim_q;
    xor_en_d     = xor_en_q;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    tbl_raddr    = {dim_q, col_q};
    cctl         = '0;
    cctl.dim     = dim_q;
    cctl.xor_en  = xor_en_q;
    out_load     = 1'b0;
    out_coord_d  = new_coord & mask;
    out_dim_d    = spg_pkg::DimFieldW'(dim_q);
    out_status_d = 1'b0;
    out_last_d   = (dim_q == last_dim);

    case (state_q)
      spg_pkg::StIdle: begin
        if (req_fire) begin
          case (spg_pkg::func_e'(req_i.func))
            spg_pkg::FuncLoad: begin
              tbl_we = (spg_pkg::CmpW'(req_i.dim_index) <
                        spg_pkg::CmpW'(spg_pkg::MAX_DIMS)) &&
                       (spg_pkg::CmpW'(req_i.column_index) <
                        spg_pkg::CmpW'(spg_pkg::MAX_COLUMNS));
            end
            spg_pkg::FuncNext: begin
              if (!started_q) begin
                started_d = 1'b1;
                counter_d = '0;
                xor_en_d  = 1'b0;
                dim_d     = '0;
                state_d   = spg_pkg::StEmit;
              end else begin
                col_d   = '0;
                state_d = spg_pkg::StScan;
              end
            end
            spg_pkg::FuncRestart: begin
              cctl.clear = 1'b1;
              counter_d  = '0;
              started_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // Lowest zero bit of the counter, one bit a cycle
      spg_pkg::StScan: begin
        if (spg_pkg::CmpW'(col_q) >= spg_pkg::CmpW'(eff_cols)) begin
          state_d = spg_pkg::StExhaust;
        end else if (!counter_q[col_q]) begin
          counter_d = counter_q + spg_pkg::CntW'(1);
          xor_en_d  = 1'b1;
          dim_d     = '0;
          tbl_re    = 1'b1;
          tbl_raddr = {spg_pkg::DimW'(0), col_q};
          state_d   = spg_pkg::StEmit;
        end else begin
          col_d = col_q + spg_pkg::ColW'(1);
        end
      end

      // One dimension a cycle while the output register is free, next table word fetched alongside
      spg_pkg::StEmit: begin
        if (out_free) begin
          out_load    = 1'b1;
          cctl.update = xor_en_q;
          if (dim_q == last_dim) begin
            state_d = spg_pkg::StIdle;
          end else begin
            dim_d     = dim_q + spg_pkg::DimW'(1);
            tbl_re    = 1'b1;
            tbl_raddr = {dim_q + spg_pkg::DimW'(1), col_q};
          end
        end
      end

      spg_pkg::StExhaust: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_coord_d  = '0;
          out_dim_d    = '0;
          out_status_d = 1'b1;
          out_last_d   = 1'b1;
          state_d      = spg_pkg::StIdle;
        end
      end

      default: begin
        state_d = spg_pkg::StIdle;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spg_pkg::StIdle;
      counter_q <= '0;
      started_q <= 1'b0;
      col_q     <= '0;
      dim_q     <= '0;
      xor_en_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
      started_q <= started_d;
      col_q     <= col_d;
      dim_q     <= dim_d;
      xor_en_q  <= xor_en_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_coord_q  <= out_coord_d;
      out_dim_q    <= out_dim_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.coordinate = out_coord_q;
  assign res_o.coord_dim  = out_dim_q;
  assign res_o.status     = out_status_q;
  assign res_o.last       = out_last_q;

  // Direction numbers
  spg_dir_table u_dir_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_we),
    .wr_addr_i (tbl_waddr),
    .wr_data_i (req_i.direction_value),
    .rd_en_i   (tbl_re),
    .rd_addr_i (tbl_raddr),
    .rd_data_o (dir_word)
  );

  // Coordinates and XOR unit
  spg_coord_store u_coord_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cctl),
    .dir_word_i (dir_word),
    .coord_o    (new_coord)
  );

`ifndef SYNTH
  // A next request always holds off the following request
  a_next_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_i.func == spg_pkg::FuncNext) |=> !req_i.ready)
    else $error("request taken during a next request");

  // Exhausted result carries no coordinate and closes the request
  a_exhaust_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status |-> res_o.last && (res_o.coordinate == '0) &&
    (res_o.coord_dim == '0))
    else $error("malformed exhausted result");

  // Results appear only from the emitting states
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |->
    ($past(state_q) == spg_pkg::StEmit || $past(state_q) == spg_pkg::StExhaust))
    else $error("result raised outside emit");

  // Counter stays at zero until the first point of a sequence
  a_counter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> (counter_q == '0))
    else $error("counter moved before start");
`endif

endmodule

// ===== hdl/spg_dir_table.sv =====
// ----------------------------------------------------------------------------
// spg_dir_table
// Direction number memory, one word per dimension and column, registered read.
// ----------------------------------------------------------------------------
module spg_dir_table (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [spg_pkg::AddrW-1:0]  wr_addr_i,
  input  logic [spg_pkg::WordW-1:0]  wr_data_i,
  input  logic                       rd_en_i,
  input  logic [spg_pkg::AddrW-1:0]  rd_addr_i,
  output logic [spg_pkg::WordW-1:0]  rd_data_o
);

  logic [spg_pkg::WordW-1:0] mem_q [spg_pkg::TblDepth];
  logic [spg_pkg::WordW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/spg_coord_store.sv =====
// ----------------------------------------------------------------------------
// spg_coord_store
// Last integer coordinate of every dimension and the shared XOR update unit.
// ----------------------------------------------------------------------------
module spg_coord_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spg_pkg::coord_ctrl_t        ctrl_i,
  input  logic [spg_pkg::WordW-1:0]   dir_word_i,
  output logic [spg_pkg::WordW-1:0]   coord_o
);

  logic [spg_pkg::WordW-1:0] store_q [spg_pkg::MAX_DIMS];
  logic [spg_pkg::WordW-1:0] xor_word;

  // Shared XOR unit: selected coordinate with this column's direction word
  assign xor_word = ctrl_i.xor_en ? dir_word_i : '0;
  assign coord_o  = store_q[ctrl_i.dim] ^ xor_word;

  // Store: cleared on reset and restart, one dimension written per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spg_pkg::MAX_DIMS; i++) begin
        store_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < spg_pkg::MAX_DIMS; i++) begin
        store_q[i] <= '0;
      end
    end else if (ctrl_i.update) begin
      store_q[ctrl_i.dim] <= coord_o;
    end
  end

endmodule

// ===== verif/sobol_point_generator_checker.sv =====
// ----------------------------------------------------------------------------
// sobol_point_generator_checker
// Watches the configuration port and both channels of the Sobol point
// generator, predicts the coordinates of every accepted request and compares
// each result, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sobol_point_generator_checker
  import spg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  spg_req_if                  req_i,
  spg_res_if                  res_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  localparam logic StatusPoint     = 1'b0;
  localparam logic StatusExhausted = 1'b1;

  typedef struct packed {
    logic [WordW-1:0]     coordinate;
    logic [DimFieldW-1:0] coord_dim;
    logic                 status;
    logic                 last;
  } coord_res_t;

  // Shadow state of the generator
  logic [WordW-1:0]    dir_words [MAX_DIMS][MAX_COLUMNS];
  logic [WordW-1:0]    coord_words [MAX_DIMS];
  logic [CntW-1:0]     point_count;
  logic                seq_started;
  logic [DimsCfgW-1:0] dims_reg;
  logic [ColsCfgW-1:0] cols_reg;

  coord_res_t  coords_due_q [$];
  int unsigned fails;

  // 0 behaves as one dimension, anything past the table as the full table
  function automatic int active_dims();
    if (dims_reg == '0) return 1;
    if (int'(dims_reg) > MAX_DIMS) return MAX_DIMS;
    return int'(dims_reg);
  endfunction

  function automatic int active_cols();
    if (int'(cols_reg) > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(cols_reg);
  endfunction

  function automatic logic [WordW-1:0] fraction_bits();
    logic [WordW-1:0] m;
    m = '1;
    if (active_cols() < WordW) m = (WordW'(1) << active_cols()) - WordW'(1);
    return m;
  endfunction

  // Queue one coordinate per active dimension, last mark on the final one
  task automatic queue_point();
    coord_res_t       r;
    logic [WordW-1:0] m;
    int               n;
    m = fraction_bits();
    n = active_dims();
    for (int i = 0; i < n; i++) begin
      r.coordinate = coord_words[i] & m;
      r.coord_dim  = DimFieldW'(i);
      r.status     = StatusPoint;
      r.last       = (i == n - 1);
      coords_due_q.push_back(r);
    end
  endtask

  task automatic predict_request(logic [FuncW-1:0] f, logic [DimFieldW-1:0] d,
                                 logic [ColFieldW-1:0] c, logic [WordW-1:0] v);
    coord_res_t r;
    int         col;
    case (f)
      FuncLoad: begin
        // column 31 lies outside the table and is dropped
        if (int'(c) < MAX_COLUMNS && int'(d) < MAX_DIMS) dir_words[d][c] = v;
      end
      FuncRestart: begin
        for (int i = 0; i < MAX_DIMS; i++) coord_words[i] = '0;
        point_count = '0;
        seq_started = 1'b0;
      end
      FuncNext: begin
        if (!seq_started) begin
          // first point after a restart is the stored all-zero point
          seq_started = 1'b1;
          point_count = '0;
          queue_point();
        end else begin
          col = CntW;
          for (int b = 0; b < CntW; b++) begin
            if (!point_count[b]) begin
              col = b;
              break;
            end
          end
          if (col >= active_cols()) begin
            r.coordinate = '0;
            r.coord_dim  = '0;
            r.status     = StatusExhausted;
            r.last       = 1'b1;
            coords_due_q.push_back(r);
          end else begin
            for (int i = 0; i < active_dims(); i++)
              coord_words[i] = coord_words[i] ^ dir_words[i][col];
            point_count = point_count + 1'b1;
            queue_point();
          end
        end
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coord_res_t want;
    coord_res_t got;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        coord_words[i] = '0;
        for (int j = 0; j < MAX_COLUMNS; j++) dir_words[i][j] = '0;
      end
      point_count = '0;
      seq_started = 1'b0;
      dims_reg    = DimsCfgW'(1);
      cols_reg    = ColsCfgW'(MAX_COLUMNS);
      coords_due_q.delete();
      fails       = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDimensions:  dims_reg = cfg_wdata_i[DimsCfgW-1:0];
          CfgColumnCount: cols_reg = cfg_wdata_i[ColsCfgW-1:0];
          default: ;
        endcase
      end

      // result check against the oldest prediction
      if (res_i.valid && res_i.ready) begin
        got.coordinate = res_i.coordinate;
        got.coord_dim  = res_i.coord_dim;
        got.status     = res_i.status;
        got.last       = res_i.last;
        if (coords_due_q.size() == 0) begin
          $display("%0t: unexpected result: coordinate %h dim %0d status %b last %b",
                   $time, got.coordinate, got.coord_dim, got.status, got.last);
          fails++;
        end else begin
          want = coords_due_q.pop_front();
          if (got.coordinate !== want.coordinate || got.coord_dim !== want.coord_dim ||
              got.status !== want.status || got.last !== want.last) begin
            $display("%0t: result mismatch: expected coordinate %h dim %0d status %b last %b",
                     $time, want.coordinate, want.coord_dim, want.status, want.last);
            $display("%0t:                  actual   coordinate %h dim %0d status %b last %b",
                     $time, got.coordinate, got.coord_dim, got.status, got.last);
            fails++;
          end
        end
      end

      // accepted request
      if (req_i.valid && req_i.ready)
        predict_request(req_i.func, req_i.dim_index, req_i.column_index,
                        req_i.direction_value);

      pending_o    <= coords_due_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== verif/sobol_point_generator_test.sv =====
// ----------------------------------------------------------------------------
// sobol_point_generator_test
// Drives the Sobol point generator with directed and random requests under
// several register settings and idling patterns; the checker beside the
// block predicts and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module sobol_point_generator_test;
  import spg_pkg::*;

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam int unsigned      CycleLimit = 1000000;
  localparam int               LongHold   = 400;
  localparam int               NumPhases  = 6;
  localparam int               PhaseReqs  = 50;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         pending;
  int unsigned         fail_count;

  spg_req_if req ();
  spg_res_if res ();

  sobol_point_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .res_o      (res)
  );

  sobol_point_generator_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req),
    .res_i       (res),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // Idling controls shared with the receiver process
  int unsigned idle_pct;
  int unsigned stall_pct;
  int          hold_left;

  // Stimulus bookkeeping: which table words hold data, and where the
  // counter stands, so that no request reads a word never loaded
  bit              word_loaded [MAX_DIMS][MAX_COLUMNS];
  bit              seq_live;
  logic [CntW-1:0] seq_count;
  int              use_dims;
  int              use_cols;

  int unsigned phase_dims [NumPhases] = '{32, 63, 7, 33, 20, 0};
  int unsigned phase_cols [NumPhases] = '{31, 3, 5, 2, 31, 4};

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[sobol_point_generator] ERROR");
    $finish;
  end

  // Result side: random stalls plus one long hold-off
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Present one request; returns at the edge that accepts it, valid still high
  task automatic send_request(logic [FuncW-1:0] f, logic [DimFieldW-1:0] d,
                              logic [ColFieldW-1:0] c, logic [WordW-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid           <= 1'b1;
    req.func            <= f;
    req.dim_index       <= d;
    req.column_index    <= c;
    req.direction_value <= v;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic load_word(int d, int c, logic [WordW-1:0] v);
    send_request(FuncLoad, DimFieldW'(d), ColFieldW'(c), v);
    if (c < MAX_COLUMNS) word_loaded[d][c] = 1'b1;
  endtask

  task automatic restart_sequence();
    send_request(FuncRestart, DimFieldW'($urandom()), ColFieldW'($urandom()),
                 WordW'($urandom()));
    seq_live  = 1'b0;
    seq_count = '0;
  endtask

  // Next point, loading first any word of the column it is about to use
  task automatic next_point();
    int col;
    if (!seq_live) begin
      seq_live  = 1'b1;
      seq_count = '0;
    end else begin
      col = 0;
      while (col < CntW && seq_count[col]) col++;
      if (col < use_cols) begin
        for (int i = 0; i < use_dims; i++)
          if (!word_loaded[i][col]) load_word(i, col, WordW'($urandom()));
        seq_count = seq_count + 1'b1;
      end
    end
    send_request(FuncNext, DimFieldW'($urandom()), ColFieldW'($urandom()),
                 WordW'($urandom()));
  endtask

  // Lower valid and let every outstanding result arrive
  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called once the block has drained
  task automatic write_register(logic [CfgIdxW-1:0] idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgDataW'(value);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgDimensions)
      use_dims = (value == 0) ? 1 : ((value > MAX_DIMS) ? MAX_DIMS : int'(value));
    else if (idx == CfgColumnCount)
      use_cols = (value > MAX_COLUMNS) ? MAX_COLUMNS : int'(value);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 60; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 60; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  task automatic random_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50)
      next_point();
    else if (r < 75)
      load_word($urandom_range(MAX_DIMS - 1), $urandom_range(MAX_COLUMNS - 1),
                WordW'($urandom()));
    else if (r < 83)
      restart_sequence();
    else if (r < 88)
      load_word($urandom_range(MAX_DIMS - 1), MAX_COLUMNS, WordW'($urandom()));
    else if (r < 92)
      send_request(FuncUnused, DimFieldW'($urandom()), ColFieldW'($urandom()),
                   WordW'($urandom()));
    else begin
      // sender pauses until the point is fully out
      next_point();
      drain_results();
    end
  endtask

  // Stimulus
  initial begin
    req.valid           <= 1'b0;
    req.func            <= FuncLoad;
    req.dim_index       <= '0;
    req.column_index    <= '0;
    req.direction_value <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CfgDimensions;
    cfg_wdata           <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    seq_live  = 1'b0;
    seq_count = '0;
    use_dims  = 1;
    use_cols  = MAX_COLUMNS;
    rst_ni    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, one dimension over all columns
    next_point();
    load_word(0, 0, '1);
    load_word(MAX_DIMS - 1, MAX_COLUMNS - 1, '0);
    load_word(7, MAX_COLUMNS, WordW'($urandom()));
    send_request(FuncUnused, '1, '1, '1);
    next_point();
    next_point();
    next_point();
    restart_sequence();
    next_point();
    drain_results();

    // Directed: no column bits, so only the zero point then exhausted
    write_register(CfgDimensions, 0);
    write_register(CfgColumnCount, 0);
    next_point();
    next_point();
    next_point();
    drain_results();

    // Directed: single column
    write_register(CfgColumnCount, 1);
    restart_sequence();
    next_point();
    next_point();
    next_point();
    next_point();
    drain_results();

    // Random phases across settings and idling patterns
    for (int p = 0; p < NumPhases; p++) begin
      write_register(CfgDimensions, phase_dims[p]);
      write_register(CfgColumnCount, phase_cols[p]);
      set_idling(p % 4);
      restart_sequence();
      // long output hold-off while requests keep coming
      if (p == 0) hold_left = LongHold;
      for (int k = 0; k < PhaseReqs; k++) random_request();
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("[sobol_point_generator] OK");
    else
      $display("[sobol_point_generator] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spg_pkg.sv
hdl/spg_if.sv
hdl/spg_dir_table.sv
hdl/spg_coord_store.sv
hdl/sobol_point_generator.sv
verif/sobol_point_generator_checker.sv
verif/sobol_point_generator_test.sv
